[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk and disabled while rst_n is low
`define SPQ_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/spq_pkg.sv]
// package: widths, request and status codes, types for the priority queue
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int REQ_W    = 2;
    localparam int PRIO_W   = 16;
    localparam int HANDLE_W = 32;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef logic signed [PRIO_W-1:0] prio_t;
    typedef logic [HANDLE_W-1:0]      handle_t;
    typedef logic [OCC_W-1:0]         occ_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

endpackage

[hw/rtl/spq_if.sv]
// request and response channel interfaces
interface spq_req_if;
    import spq_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic signed [PRIO_W-1:0] item_priority;
    logic [HANDLE_W-1:0] item_handle;

    modport source (output valid, output req_type, output item_priority,
                    output item_handle, input ready);
    modport sink   (input valid, input req_type, input item_priority,
                    input item_handle, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic                head_valid;
    logic signed [PRIO_W-1:0] head_priority;
    logic [HANDLE_W-1:0] head_handle;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output head_valid,
                    output head_priority, output head_handle,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input head_valid,
                    input head_priority, input head_handle,
                    input entry_count, output ready);
endinterface

[hw/rtl/stable_priority_queue.sv]
// top level: bounded stable priority queue of handles
//
//  channel  dir  payload                                               handshake
//  req      in   req_type, item_priority, item_handle                  valid/ready
//  rsp      out  status, head_valid, head_priority, head_handle,
//                entry_count                                            valid/ready
//
// each request word is first captured, then executed: all slots compare in parallel
// and the slot row shifts; the response register then holds it.
// a new request is taken while the previous response is being taken (rsp.ready high).
// rst_n (async, active low) empties the queue; slot contents are not cleared.
// a stalled response holds the block: no request is taken until it leaves.
module stable_priority_queue (
    input  logic   clk,
    input  logic   rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    ctl_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    spq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req.req_type),
        .item_priority (req.item_priority),
        .item_handle   (req.item_handle),
        .status        (rsp.status),
        .head_valid    (rsp.head_valid),
        .head_priority (rsp.head_priority),
        .head_handle   (rsp.head_handle),
        .entry_count   (rsp.entry_count)
    );

endmodule

[hw/rtl/spq_ctrl.sv]
// controller: request/response handshake and two-state sequencer
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output spq_pkg::ctl_cmd_t cmd
);
    import spq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // the response word in flight may leave on this same edge
                req_ready   = !rsp_valid_reg || rsp_ready;
                cmd.capture = req_ready && req_valid;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.execute)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[hw/rtl/spq_datapath.sv]
// datapath: sorted slot row, per-slot compare, shift insert/delete, response register
module spq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_pkg::ctl_cmd_t             cmd,
    input  logic [spq_pkg::REQ_W-1:0]     req_type,
    input  spq_pkg::prio_t                item_priority,
    input  spq_pkg::handle_t              item_handle,
    output logic [spq_pkg::STAT_W-1:0]    status,
    output logic                          head_valid,
    output spq_pkg::prio_t                head_priority,
    output spq_pkg::handle_t              head_handle,
    output logic [spq_pkg::COUNT_W-1:0]   entry_count
);
    import spq_pkg::*;

    // captured request
    logic [REQ_W-1:0] req_type_reg;
    prio_t            req_prio_reg;
    handle_t          req_handle_reg;

    // slot row, slot 0 is the head
    prio_t   slot_prio_reg   [QUEUE_DEPTH];
    handle_t slot_handle_reg [QUEUE_DEPTH];
    prio_t   slot_prio_next  [QUEUE_DEPTH];
    handle_t slot_handle_next[QUEUE_DEPTH];
    occ_t    occ_reg;
    occ_t    occ_next;

    logic [QUEUE_DEPTH-1:0] slot_valid;
    logic [QUEUE_DEPTH-1:0] prio_le;
    logic [QUEUE_DEPTH-1:0] handle_hit;
    logic [QUEUE_DEPTH-1:0] first_hit_mask;
    logic [QUEUE_DEPTH-1:0] drop_mask;
    logic                   do_insert;
    logic                   do_drop;
    logic [STAT_W-1:0]      status_next;
    logic [31:0]            occ_ext;

    logic [STAT_W-1:0]  status_reg;
    logic               head_valid_reg;
    prio_t              head_prio_reg;
    handle_t            head_handle_reg;
    logic [COUNT_W-1:0] count_reg;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_valid[i] = OCC_W'(i) < occ_reg;
            prio_le[i]    = slot_valid[i] && (slot_prio_reg[i] <= req_prio_reg);
            handle_hit[i] = slot_valid[i] && (slot_handle_reg[i] == req_handle_reg);
        end
        // every slot at or after the first matching handle moves up one
        first_hit_mask[0] = handle_hit[0];
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            first_hit_mask[i] = first_hit_mask[i-1] | handle_hit[i];
        end
    end

    always_comb
    begin
        do_insert   = 1'b0;
        do_drop     = 1'b0;
        drop_mask   = '0;
        occ_next    = occ_reg;
        status_next = STAT_OK;
        unique case (req_type_reg)
            REQ_INSERT:
            begin
                if (occ_reg == OCC_W'(QUEUE_DEPTH))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            REQ_POP:
            begin
                if (occ_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    do_drop   = 1'b1;
                    drop_mask = '1;
                    occ_next  = occ_reg - 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (handle_hit == '0)
                begin
                    status_next = STAT_NOTFOUND;
                end
                else
                begin
                    do_drop   = 1'b1;
                    drop_mask = first_hit_mask;
                    occ_next  = occ_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_prio_next[i]   = slot_prio_reg[i];
            slot_handle_next[i] = slot_handle_reg[i];
        end
        // head slot
        if (do_insert && !prio_le[0])
        begin
            slot_prio_next[0]   = req_prio_reg;
            slot_handle_next[0] = req_handle_reg;
        end
        else if (do_drop && drop_mask[0])
        begin
            slot_prio_next[0]   = slot_prio_reg[1];
            slot_handle_next[0] = slot_handle_reg[1];
        end
        // insert: slots after the last entry with priority <= new shift down
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            if (do_insert && !prio_le[i])
            begin
                if (prio_le[i-1])
                begin
                    slot_prio_next[i]   = req_prio_reg;
                    slot_handle_next[i] = req_handle_reg;
                end
                else
                begin
                    slot_prio_next[i]   = slot_prio_reg[i-1];
                    slot_handle_next[i] = slot_handle_reg[i-1];
                end
            end
        end
        for (int i = 1; i < QUEUE_DEPTH - 1; i++)
        begin
            if (do_drop && drop_mask[i])
            begin
                slot_prio_next[i]   = slot_prio_reg[i+1];
                slot_handle_next[i] = slot_handle_reg[i+1];
            end
        end
    end

    assign occ_ext = 32'(occ_next);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg   <= req_type;
            req_prio_reg   <= item_priority;
            req_handle_reg <= item_handle;
        end
        if (cmd.execute)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_prio_reg[i]   <= slot_prio_next[i];
                slot_handle_reg[i] <= slot_handle_next[i];
            end
            status_reg     <= status_next;
            head_valid_reg <= occ_next != '0;
            head_prio_reg  <= (occ_next != '0) ? slot_prio_next[0] : '0;
            head_handle_reg <= (occ_next != '0) ? slot_handle_next[0] : '0;
            count_reg      <= occ_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.execute)
        begin
            occ_reg <= occ_next;
        end
    end

    assign status        = status_reg;
    assign head_valid    = head_valid_reg;
    assign head_priority = head_prio_reg;
    assign head_handle   = head_handle_reg;
    assign entry_count   = count_reg;

endmodule

[hw/rtl/spq_checker.sv]
// port-level checker for the priority queue, bound to the top level
`include "assert_macros.svh"

module spq_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [spq_pkg::STAT_W-1:0]    status,
    input  logic                          head_valid,
    input  spq_pkg::prio_t                head_priority,
    input  spq_pkg::handle_t              head_handle
);
    import spq_pkg::*;

    `SPQ_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
    `SPQ_CHECK_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken during execute")
    `SPQ_CHECK(a_empty_head_zero, rsp_valid && !head_valid, head_priority == '0 && head_handle == '0, "empty queue shows a head")
    `SPQ_CHECK(a_pop_empty, rsp_valid && status == STAT_EMPTY, !head_valid, "pop on empty left a head")
    `SPQ_CHECK(a_full_has_head, rsp_valid && status == STAT_FULL, head_valid, "full queue shows no head")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .head_valid    (rsp.head_valid),
    .head_priority (rsp.head_priority),
    .head_handle   (rsp.head_handle)
);

[tb/stable_priority_queue_tb.sv]
// testbench for the stable priority queue: directed, backpressure and random traffic
module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NOOP = 2'd3;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic               head_valid;
        prio_t              head_priority;
        handle_t            head_handle;
        logic [COUNT_W-1:0] entry_count;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n;

    spq_req_if req_bus();
    spq_rsp_if rsp_bus();

    stable_priority_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #6 clk = ~clk;

    // shadow copy of the sorted slot row
    prio_t   shadow_prio   [QUEUE_DEPTH];
    handle_t shadow_handle [QUEUE_DEPTH];
    int      shadow_count;

    queue_result_t pending_results[$];
    int mismatches;
    int hold_cycles;
    bit src_idles;
    bit sink_idles;
    int idle_cycles;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void shift_out(int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_prio[i]   = shadow_prio[i + 1];
            shadow_handle[i] = shadow_handle[i + 1];
        end
        shadow_count--;
    endfunction

    // updates the shadow queue and returns the response the request must produce
    function automatic queue_result_t apply_request(logic [REQ_W-1:0] kind, prio_t p,
                                                    handle_t h);
        queue_result_t res;
        int pos;
        res.status = STAT_OK;
        case (kind)
            REQ_INSERT:
            begin
                if (shadow_count >= QUEUE_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    // new word goes behind every equal priority
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] <= p)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_prio[i]   = shadow_prio[i - 1];
                        shadow_handle[i] = shadow_handle[i - 1];
                    end
                    shadow_prio[pos]   = p;
                    shadow_handle[pos] = h;
                    shadow_count++;
                end
            end
            REQ_POP:
            begin
                if (shadow_count == 0)
                    res.status = STAT_EMPTY;
                else
                    shift_out(0);
            end
            REQ_REMOVE:
            begin
                pos = 0;
                while (pos < shadow_count && shadow_handle[pos] != h)
                    pos++;
                if (pos < shadow_count)
                    shift_out(pos);
                else
                    res.status = STAT_NOTFOUND;
            end
            default:
            begin
            end
        endcase
        res.head_valid    = (shadow_count > 0);
        res.head_priority = (shadow_count > 0) ? shadow_prio[0] : '0;
        res.head_handle   = (shadow_count > 0) ? shadow_handle[0] : '0;
        res.entry_count   = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic send_word(logic [REQ_W-1:0] kind, prio_t p, handle_t h);
        int gap;
        gap = src_idles ? gap_length() : 0;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= kind;
        req_bus.item_priority <= p;
        req_bus.item_handle   <= h;
        do
            @(posedge clk);
        while (!req_bus.ready);
        pending_results.push_back(apply_request(kind, p, h));
    endtask

    task automatic check_response();
        queue_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("response with nothing pending", 0, rsp_bus.status);
            return;
        end
        want = pending_results.pop_front();
        if (rsp_bus.status !== want.status)
            report_mismatch("status", want.status, rsp_bus.status);
        if (rsp_bus.head_valid !== want.head_valid)
            report_mismatch("head_valid", want.head_valid, rsp_bus.head_valid);
        if (rsp_bus.head_priority !== want.head_priority)
            report_mismatch("head_priority", want.head_priority, rsp_bus.head_priority);
        if (rsp_bus.head_handle !== want.head_handle)
            report_mismatch("head_handle", want.head_handle, rsp_bus.head_handle);
        if (rsp_bus.entry_count !== want.entry_count)
            report_mismatch("entry_count", want.entry_count, rsp_bus.entry_count);
    endtask

    // response side: check accepted words, then pick ready for the next cycle
    always @(posedge clk)
    begin : response_side
        int g;
        if (rsp_bus.valid && rsp_bus.ready)
            check_response();
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
        end
        else if (sink_idles)
        begin
            g = gap_length();
            rsp_bus.ready <= (g == 0);
            if (g > 1)
                hold_cycles = g - 1;
        end
        else
            rsp_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_directed_cases();
        src_idles  = 1'b1;
        sink_idles = 1'b1;
        send_word(REQ_POP, 16'sd0, 32'h0);
        send_word(REQ_REMOVE, 16'sd0, 32'h0);
        send_word(REQ_NOOP, 16'sh7FFF, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 16'sh7FFF, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 16'sh8000, 32'h0);
        // three equal priorities, one handle used twice
        send_word(REQ_INSERT, 16'sd5, 32'hA);
        send_word(REQ_INSERT, 16'sd5, 32'hB);
        send_word(REQ_INSERT, 16'sd5, 32'hA);
        send_word(REQ_INSERT, -16'sd1, 32'hC);
        send_word(REQ_INSERT, 16'sd0, 32'hD);
        send_word(REQ_REMOVE, 16'sd0, 32'hA);
        send_word(REQ_NOOP, 16'sh5555, 32'h1234_5678);
        send_word(REQ_REMOVE, 16'sd0, 32'h0001_2345);
        send_word(REQ_REMOVE, 16'sd0, 32'h0);
        repeat (6) send_word(REQ_POP, 16'sd0, 32'h0);
        send_word(REQ_POP, 16'sd0, 32'h0);
        send_word(REQ_REMOVE, 16'sd0, 32'hFFFF_FFFF);
    endtask

    // receiver stalls long while inserts keep coming: the queue fills and overflows
    task automatic test_fill_under_backpressure();
        src_idles  = 1'b0;
        sink_idles = 1'b0;
        hold_cycles = 300;
        repeat (QUEUE_DEPTH + 6)
            send_word(REQ_INSERT, prio_t'($urandom_range(0, 6) - 3), $urandom_range(0, 15));
        repeat (QUEUE_DEPTH + 2)
            send_word(REQ_POP, prio_t'($urandom), $urandom);
    endtask

    task automatic test_random_traffic(int count);
        int r;
        bit fill_phase;
        logic [REQ_W-1:0] kind;
        prio_t p;
        handle_t h;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                fill_phase = ((n / 100) % 2 == 0);
                src_idles  = ($urandom_range(0, 3) != 0);
                sink_idles = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 3) == 0)
                    hold_cycles = $urandom_range(50, 150);
            end
            r = $urandom_range(0, 99);
            if (fill_phase)
                kind = (r < 65) ? REQ_INSERT : (r < 80) ? REQ_POP :
                       (r < 96) ? REQ_REMOVE : REQ_NOOP;
            else
                kind = (r < 30) ? REQ_INSERT : (r < 60) ? REQ_POP :
                       (r < 96) ? REQ_REMOVE : REQ_NOOP;
            r = $urandom_range(0, 99);
            if (r < 50)
                p = prio_t'($urandom_range(0, 8) - 4);
            else if (r < 85)
                p = prio_t'($urandom);
            else if (r < 92)
                p = 16'sh8000;
            else
                p = 16'sh7FFF;
            r = $urandom_range(0, 99);
            if (kind == REQ_REMOVE && shadow_count > 0 && r < 75)
                h = shadow_handle[$urandom_range(0, shadow_count - 1)];
            else if (r < 60)
                h = $urandom_range(0, 15);
            else if (r < 70)
                h = 32'hFFFF_FFFF - $urandom_range(0, 3);
            else
                h = $urandom;
            send_word(kind, p, h);
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_INSERT;
        req_bus.item_priority = '0;
        req_bus.item_handle   = '0;
        rsp_bus.ready         = 1'b0;
        shadow_count = 0;
        mismatches   = 0;
        hold_cycles  = 0;
        idle_cycles  = 0;
        src_idles    = 1'b0;
        sink_idles   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_under_backpressure();
        test_random_traffic(1500);

        req_bus.valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/stable_priority_queue.sv
hw/rtl/spq_checker.sv
tb/stable_priority_queue_tb.sv
